// ----- rtl/glyph_bitmap_expander_macros.svh -----
// ----------------------------------------------------------------------------
// Glyph bitmap expander assertion macros
// Shared concurrent assertion forms, clocked on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_BITMAP_EXPANDER_MACROS_SVH
`define GLYPH_BITMAP_EXPANDER_MACROS_SVH

// same-cycle implication
`define GBE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gbe_pkg.sv -----
// ----------------------------------------------------------------------------
// Glyph bitmap expander package
// Sizes, register codes, queue entry type and side clamping.
// ----------------------------------------------------------------------------
package gbe_pkg;

    localparam int MAX_GLYPH_SIDE = 64;
    localparam int ROW_W          = $clog2(MAX_GLYPH_SIDE);
    localparam int MAX_BPR        = (MAX_GLYPH_SIDE + 7) / 8;
    localparam int COL_W          = (MAX_BPR > 1) ? $clog2(MAX_BPR) : 1;

    localparam int BYTE_W     = 8;
    localparam int ORG_W      = 10;
    localparam int SIDE_CFG_W = 7;
    localparam int XY_W       = 11;
    localparam int VAL_W      = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int TDATA_W = ((2 * XY_W + VAL_W + 7) / 8) * 8;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [VAL_W-1:0] PEN_CLEAR = VAL_W'(2);

    typedef logic [ROW_W:0] side_t;
    typedef logic [COL_W:0] bpr_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_GLYPH_W  = 3'd2,
        REG_GLYPH_H  = 3'd3,
        REG_PEN      = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic [XY_W-1:0]   base_x;
        logic [XY_W-1:0]   pix_y;
        logic [BYTE_W-1:0] bits;
        logic [BYTE_W-1:0] mask;
        logic [VAL_W-1:0]  set_val;
        logic [VAL_W-1:0]  clr_val;
        logic              glyph_end;
    } job_t;

    function automatic side_t clamp_side(input logic [SIDE_CFG_W-1:0] v);
        side_t r;
        if (v == '0) begin
            r = side_t'(1);
        end else if (32'(v) > MAX_GLYPH_SIDE) begin
            r = side_t'(MAX_GLYPH_SIDE);
        end else begin
            r = side_t'(v);
        end
        return r;
    endfunction

endpackage

// ----- rtl/gbe_front.sv -----
// ----------------------------------------------------------------------------
// Glyph bitmap expander front end
// Holds configuration, walks the glyph counters and classifies each byte.
// ----------------------------------------------------------------------------
module gbe_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gbe_pkg::BYTE_W-1:0]      s_tdata,
    input  logic                            q_full,
    output logic                            job_valid,
    output gbe_pkg::job_t                   job
);
    import gbe_pkg::*;

    logic [ORG_W-1:0]      origin_x_reg, origin_x_next;
    logic [ORG_W-1:0]      origin_y_reg, origin_y_next;
    logic [SIDE_CFG_W-1:0] glyph_w_reg, glyph_w_next;
    logic [SIDE_CFG_W-1:0] glyph_h_reg, glyph_h_next;
    logic [VAL_W-1:0]      pen_reg, pen_next;
    logic [COL_W-1:0]      byte_reg, byte_next;
    logic [ROW_W-1:0]      row_reg, row_next;

    side_t            w_side, h_side;
    logic [ROW_W+1:0] w_round;
    bpr_t             bpr;
    logic [COL_W-1:0] byte_cur;
    logic [ROW_W-1:0] row_cur;
    bpr_t             byte_inc;
    side_t            row_inc;
    logic             end_row, end_glyph, accept, cfg_hit;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    assign w_side  = clamp_side(glyph_w_reg);
    assign h_side  = clamp_side(glyph_h_reg);
    assign w_round = {1'b0, w_side} + (ROW_W + 2)'(7);
    assign bpr     = bpr_t'(w_round >> 3);

    assign byte_cur  = ({1'b0, byte_reg} >= bpr) ? '0 : byte_reg;
    assign row_cur   = ({1'b0, row_reg} >= h_side) ? '0 : row_reg;
    assign byte_inc  = {1'b0, byte_cur} + bpr_t'(1);
    assign row_inc   = {1'b0, row_cur} + side_t'(1);
    assign end_row   = byte_inc >= bpr;
    assign end_glyph = end_row && (row_inc >= h_side);

    always_comb begin
        job.base_x    = XY_W'(origin_x_reg) + XY_W'({byte_cur, 3'b000});
        job.pix_y     = XY_W'(origin_y_reg) + XY_W'(row_cur);
        job.bits      = s_tdata;
        job.glyph_end = end_glyph;
        if (pen_reg < PEN_CLEAR) begin
            job.mask    = '1;
            job.set_val = pen_reg;
            job.clr_val = (pen_reg == '0) ? VAL_W'(1) : '0;
        end else if (pen_reg == PEN_CLEAR) begin
            job.mask    = s_tdata;
            job.set_val = '0;
            job.clr_val = '0;
        end else begin
            job.mask    = s_tdata;
            job.set_val = pen_reg;
            job.clr_val = pen_reg;
        end
    end

    // drop bytes that draw nothing
    assign job_valid = accept && (job.mask != '0);

    always_comb begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        glyph_w_next  = glyph_w_reg;
        glyph_h_next  = glyph_h_reg;
        pen_next      = pen_reg;
        cfg_hit       = 1'b0;
        if (cfg_valid) begin
            case (cfg_reg_e'(cfg_index))
                REG_ORIGIN_X: begin
                    origin_x_next = cfg_data[ORG_W-1:0];
                    cfg_hit       = 1'b1;
                end
                REG_ORIGIN_Y: begin
                    origin_y_next = cfg_data[ORG_W-1:0];
                    cfg_hit       = 1'b1;
                end
                REG_GLYPH_W: begin
                    glyph_w_next = cfg_data[SIDE_CFG_W-1:0];
                    cfg_hit      = 1'b1;
                end
                REG_GLYPH_H: begin
                    glyph_h_next = cfg_data[SIDE_CFG_W-1:0];
                    cfg_hit      = 1'b1;
                end
                REG_PEN: begin
                    pen_next = cfg_data[VAL_W-1:0];
                    cfg_hit  = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        byte_next = byte_reg;
        row_next  = row_reg;
        if (cfg_hit) begin
            byte_next = '0;
            row_next  = '0;
        end else if (accept) begin
            if (end_row) begin
                byte_next = '0;
                row_next  = (row_inc >= h_side) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                byte_next = byte_inc[COL_W-1:0];
                row_next  = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            glyph_w_reg  <= SIDE_CFG_W'(8);
            glyph_h_reg  <= SIDE_CFG_W'(16);
            pen_reg      <= VAL_W'(1);
            byte_reg     <= '0;
            row_reg      <= '0;
        end else begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            glyph_w_reg  <= glyph_w_next;
            glyph_h_reg  <= glyph_h_next;
            pen_reg      <= pen_next;
            byte_reg     <= byte_next;
            row_reg      <= row_next;
        end
    end

endmodule

// ----- rtl/gbe_fifo.sv -----
// ----------------------------------------------------------------------------
// Glyph bitmap expander job queue
// Short flip-flop queue between the front end and the pixel sequencer.
// ----------------------------------------------------------------------------
module gbe_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gbe_pkg::job_t push_job,
    input  logic          pop,
    output gbe_pkg::job_t head,
    output logic          full,
    output logic          empty
);
    import gbe_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = count_reg == (QPTR_W + 1)'(QDEPTH);
    assign empty   = count_reg == '0;
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/gbe_back.sv -----
// ----------------------------------------------------------------------------
// Glyph bitmap expander pixel sequencer
// Walks queued bytes MSB first, one pixel beat per cycle while m_tready allows.
// ----------------------------------------------------------------------------
`include "glyph_bitmap_expander_macros.svh"

module gbe_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  gbe_pkg::job_t                head,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gbe_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);
    import gbe_pkg::*;

    logic [BYTE_W-1:0]  done_reg, done_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic               m_tlast_reg, m_tuser_reg;

    logic [BYTE_W-1:0] remaining, pick, rest;
    logic [2:0]        bit_pos, col;
    logic              last, load;
    logic [XY_W-1:0]   pix_x;
    logic [VAL_W-1:0]  pix_val;

    assign remaining = head.mask & ~done_reg;

    always_comb begin
        bit_pos = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (remaining[i]) begin
                bit_pos = 3'(i);
            end
        end
    end

    assign pick    = BYTE_W'(1) << bit_pos;
    assign rest    = remaining & ~pick;
    assign last    = rest == '0;
    assign col     = ~bit_pos;
    assign pix_x   = head.base_x + XY_W'(col);
    assign pix_val = head.bits[bit_pos] ? head.set_val : head.clr_val;

    assign load  = !q_empty && (!m_tvalid_reg || m_tready);
    assign q_pop = load && last;

    always_comb begin
        done_next = done_reg;
        if (load) begin
            done_next = last ? '0 : (done_reg | pick);
        end
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (load) begin
            m_tdata_reg <= TDATA_W'({pix_val, head.pix_y, pix_x});
            m_tlast_reg <= last;
            m_tuser_reg <= head.glyph_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `GBE_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "pop from empty job queue")
    `GBE_ASSERT_IMP(a_head_pending, !q_empty, remaining != '0, "queued byte has no pixel left")
    `GBE_ASSERT_IMP(a_idle_clean, q_empty, done_reg == '0, "stale pixel marks while idle")
    `GBE_ASSERT_NXT(a_pop_clears, q_pop, done_reg == '0, "pixel marks kept after pop")

endmodule

// ----- rtl/glyph_bitmap_expander.sv -----
// ----------------------------------------------------------------------------
// Glyph bitmap expander
// Expands a 1-bit glyph bitmap, MSB first, into pixel write beats.
// ----------------------------------------------------------------------------
//  channel  dir  fields (tdata/tuser from bit 0 up)
//  cfg      in   cfg_index register code, cfg_data value
//  s_       in   tdata: glyph_byte
//  m_       out  tdata: pixel_x, pixel_y, pixel_value; tlast: last_of_byte;
//                tuser: glyph_done
//
// One byte is taken per cycle while the four-entry job queue has room.
// The pixel sequencer drives one beat per cycle while m_tready allows: eight
// beats per byte in opaque pen modes, one per set bit otherwise, none for an
// empty byte. m_tready low holds a pending beat in the output register, and
// the queue absorbs up to four bytes that draw before s_tready drops.
// ----------------------------------------------------------------------------
module glyph_bitmap_expander (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gbe_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] glyph_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gbe_pkg::TDATA_W-1:0]     m_tdata,   // pixel_x, pixel_y, pixel_value
    output logic                            m_tlast,
    output logic                            m_tuser    // glyph_done
);
    import gbe_pkg::*;

    job_t job, head;
    logic job_valid, q_full, q_empty, q_pop;

    gbe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .job_valid (job_valid),
        .job       (job)
    );

    gbe_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_valid),
        .push_job (job),
        .pop      (q_pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    gbe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head     (head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- tb/sv/glyph_bitmap_expander_tb.sv -----
// ----------------------------------------------------------------------------
// Glyph bitmap expander testbench
// Feeds bitmap bytes under a range of origin, size and pen settings and
// checks every pixel write beat against a local model of the expander.
// A short directed sequence comes first. Random glyphs and broken sequences
// follow under four idling patterns. One stretch holds off the pixel side
// long enough for the byte side to back up.
// ----------------------------------------------------------------------------
module glyph_bitmap_expander_tb;
    import gbe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [VAL_W-1:0] PEN_DARK    = 16'd0;
    localparam logic [VAL_W-1:0] PEN_LIGHT   = 16'd1;
    localparam logic [VAL_W-1:0] PEN_OVERLAY = 16'd3;
    localparam logic [VAL_W-1:0] PEN_TOP     = 16'hFFFF;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [XY_W-1:0]  x;
        logic [XY_W-1:0]  y;
        logic [VAL_W-1:0] value;
        logic             last;
        logic             done;
    } pixel_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    glyph_bitmap_expander dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #4 aclk = ~aclk;

    // model state
    logic [ORG_W-1:0]      org_x   = '0;
    logic [ORG_W-1:0]      org_y   = '0;
    logic [SIDE_CFG_W-1:0] side_w  = 7'd8;
    logic [SIDE_CFG_W-1:0] side_h  = 7'd16;
    logic [VAL_W-1:0]      pen     = PEN_LIGHT;
    int unsigned           row_at  = 0;
    int unsigned           col_at  = 0;

    logic [BYTE_W-1:0] byte_backlog[$];
    pixel_t            pixel_q[$];

    int errors        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit s_beat_taken  = 1'b0;
    bit hold_go       = 1'b0;
    bit hold_on       = 1'b0;

    function automatic int unsigned fit_side(input logic [SIDE_CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_GLYPH_SIDE) begin
            return MAX_GLYPH_SIDE;
        end
        return int'(v);
    endfunction

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_ORIGIN_X: org_x  = d[ORG_W-1:0];
            REG_ORIGIN_Y: org_y  = d[ORG_W-1:0];
            REG_GLYPH_W:  side_w = d[SIDE_CFG_W-1:0];
            REG_GLYPH_H:  side_h = d[SIDE_CFG_W-1:0];
            REG_PEN:      pen    = d[VAL_W-1:0];
            default:      return;
        endcase
        row_at = 0;
        col_at = 0;
    endtask

    task automatic expand_byte(input logic [BYTE_W-1:0] b);
        int unsigned h;
        int unsigned bpr;
        int          n;
        logic        fin;
        logic        bit_set;
        logic        draw;
        logic [VAL_W-1:0] val;
        pixel_t      draws[8];
        h   = fit_side(side_h);
        bpr = (fit_side(side_w) + 7) / 8;
        n   = 0;
        if (col_at >= bpr) begin
            col_at = 0;
        end
        if (row_at >= h) begin
            row_at = 0;
        end
        fin = (col_at + 1 >= bpr) && (row_at + 1 >= h);
        for (int j = 0; j < BYTE_W; j++) begin
            bit_set = b[BYTE_W-1-j];
            if (pen < PEN_CLEAR) begin
                draw = 1'b1;
                val  = bit_set ? pen : ((pen == PEN_DARK) ? PEN_LIGHT : PEN_DARK);
            end else if (pen == PEN_CLEAR) begin
                draw = bit_set;
                val  = PEN_DARK;
            end else begin
                draw = bit_set;
                val  = pen;
            end
            if (draw) begin
                draws[n].x     = XY_W'(int'(org_x) + col_at * 8 + j);
                draws[n].y     = XY_W'(int'(org_y) + row_at);
                draws[n].value = val;
                draws[n].last  = 1'b0;
                draws[n].done  = fin;
                n++;
            end
        end
        if (n > 0) begin
            draws[n-1].last = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            pixel_q.push_back(draws[k]);
        end
        col_at++;
        if (col_at >= bpr) begin
            col_at = 0;
            row_at++;
            if (row_at >= h) begin
                row_at = 0;
            end
        end
    endtask

    task automatic flag_beat(input string what, input pixel_t want, input pixel_t seen);
        errors++;
        $display("%0t %s: expected x=%0d y=%0d value=%h last=%b done=%b,",
                 $time, what, want.x, want.y, want.value, want.last, want.done,
                 " got x=%0d y=%0d value=%h last=%b done=%b",
                 seen.x, seen.y, seen.value, seen.last, seen.done);
    endtask

    // monitor: sample handshakes at the rising edge
    always @(posedge aclk) begin : beat_check
        pixel_t seen;
        pixel_t want;
        s_beat_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                expand_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                seen.x     = m_tdata[XY_W-1:0];
                seen.y     = m_tdata[2*XY_W-1:XY_W];
                seen.value = m_tdata[2*XY_W+VAL_W-1:2*XY_W];
                seen.last  = m_tlast;
                seen.done  = m_tuser;
                if (pixel_q.size() == 0) begin
                    flag_beat("unexpected pixel beat", '0, seen);
                end else begin
                    want = pixel_q.pop_front();
                    if (seen !== want) begin
                        flag_beat("pixel mismatch", want, seen);
                    end
                end
            end
        end
    end

    // driver: change inputs at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || s_beat_taken) begin
                if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_backlog.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= !hold_on && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin : hold_off
        @(posedge hold_go);
        @(posedge aclk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on = 1'b0;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (byte_backlog.size() != 0 || s_tvalid) @(posedge aclk);
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // queue the low n bytes of a 64-bit word, most significant first
    task automatic feed(input int n, input logic [63:0] bytes);
        @(posedge aclk);
        for (int i = n - 1; i >= 0; i--) begin
            byte_backlog.push_back(bytes[8*i +: 8]);
        end
    endtask

    task automatic feed_random(input int unsigned n);
        @(posedge aclk);
        repeat (n) byte_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
        int          fed;
        int unsigned bytes;
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;
        logic [CFG_DATA_W-1:0] pd;
        settle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        fed = 0;
        while (fed < n_items) begin
            settle();
            if ($urandom_range(0, 7) == 0) begin
                // stray write, then a fragment
                write_reg(CFG_IDX_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom));
                bytes = $urandom_range(1, 6);
            end else begin
                wd = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom)
                                                 : CFG_DATA_W'($urandom_range(1, 24));
                hd = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom)
                                                 : CFG_DATA_W'($urandom_range(1, 4));
                case ($urandom_range(0, 4))
                    0:       pd = PEN_DARK;
                    1:       pd = PEN_LIGHT;
                    2:       pd = PEN_CLEAR;
                    3:       pd = PEN_OVERLAY;
                    default: pd = CFG_DATA_W'($urandom);
                endcase
                write_reg(REG_ORIGIN_X, CFG_DATA_W'($urandom));
                write_reg(REG_ORIGIN_Y, CFG_DATA_W'($urandom));
                write_reg(REG_GLYPH_W, wd);
                write_reg(REG_GLYPH_H, hd);
                write_reg(REG_PEN, pd);
                bytes = ((fit_side(wd[SIDE_CFG_W-1:0]) + 7) / 8) * fit_side(hd[SIDE_CFG_W-1:0]);
                if (bytes > 32) begin
                    bytes = $urandom_range(1, 8);
                end else begin
                    bytes = bytes * $urandom_range(1, 2);
                end
            end
            feed_random(bytes);
            fed += bytes;
        end
    endtask

    initial begin : stimulus
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: two-tone, 8 by 16
        feed(5, 64'h00FF_A580_01);
        settle();
        write_reg(REG_PEN, PEN_DARK);
        feed(2, 64'h5AFF);
        settle();
        write_reg(REG_PEN, PEN_CLEAR);
        feed(2, 64'h0081);
        settle();
        write_reg(REG_PEN, PEN_OVERLAY);
        feed(2, 64'h003C);
        settle();
        // zero sides act as one: every byte ends a glyph, empty bytes stay silent
        write_reg(REG_PEN, PEN_TOP);
        write_reg(REG_GLYPH_W, '0);
        write_reg(REG_GLYPH_H, '0);
        feed(3, 64'h0100_80);
        settle();
        // far corner, two bytes per row; spare index must not rewind the walk
        write_reg(REG_PEN, PEN_LIGHT);
        write_reg(REG_ORIGIN_X, 16'hFFFF);
        write_reg(REG_ORIGIN_Y, 16'hFFFF);
        write_reg(REG_GLYPH_W, 16'd9);
        write_reg(REG_GLYPH_H, 16'd2);
        feed(1, 64'hC3);
        settle();
        write_reg(REG_SPARE_LO, 16'hFFFF);
        feed(4, 64'h7E18_81F0);
        settle();
        write_reg(REG_SPARE_HI, '0);
        // oversized sides clamp
        write_reg(REG_ORIGIN_X, '0);
        write_reg(REG_ORIGIN_Y, '0);
        write_reg(REG_GLYPH_W, 16'h007F);
        write_reg(REG_GLYPH_H, 16'hFFFF);
        feed(2, 64'hAA55);
        settle();

        // back up the byte side behind a long pixel-side hold
        write_reg(REG_GLYPH_W, 16'd16);
        write_reg(REG_GLYPH_H, 16'd4);
        write_reg(REG_PEN, PEN_DARK);
        hold_go = 1'b1;
        feed_random(40);

        run_phase(0, 0, 55);
        run_phase(85, 0, 55);
        run_phase(0, 85, 55);
        run_phase(22, 22, 55);
        settle();

        if (errors == 0) begin
            $display("glyph_bitmap_expander regression: pass");
        end else begin
            $display("glyph_bitmap_expander regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("glyph_bitmap_expander regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gbe_pkg.sv
rtl/gbe_front.sv
rtl/gbe_fifo.sv
rtl/gbe_back.sv
rtl/glyph_bitmap_expander.sv
tb/sv/glyph_bitmap_expander_tb.sv
